/* src/pfba_pkg.sv */
// Shared types, constants and helper functions of the page frame bitmap allocator.
package pfba_pkg;

  // Map geometry: one used bit per page, eight pages per map byte
  localparam int NUM_PAGES = 4096;
  localparam int MAP_BYTES = (NUM_PAGES + 7) / 8;
  localparam int ADDR_W    = $clog2(MAP_BYTES);
  localparam int BCNT_W    = $clog2(MAP_BYTES + 1);
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(MAP_BYTES - 1);

  // Field widths of the channels
  localparam int CMD_W  = 2;
  localparam int PAGE_W = 12;
  localparam int CFG_W  = 13;
  localparam int CIDX_W = 1;
  localparam int STAT_W = 2;

  localparam logic [7:0] BYTE_FULL = 8'hFF;

  // Register reset values
  localparam logic [CFG_W-1:0] USABLE_RST   = CFG_W'(4096);
  localparam logic [CFG_W-1:0] RESERVED_RST = CFG_W'(2048);

  typedef enum logic [CMD_W-1:0] {
    CMD_ALLOC = 2'd0,
    CMD_FREE  = 2'd1,
    CMD_MARK  = 2'd2,
    CMD_INIT  = 2'd3
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    STATUS_OK    = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_RANGE = 2'd2
  } status_t;

  typedef enum logic [CIDX_W-1:0] {
    CFG_USABLE   = 1'd0,
    CFG_RESERVED = 1'd1
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_RMW,
    ST_INIT,
    ST_DONE
  } state_t;

  // Map memory access request
  typedef struct packed {
    logic              we;
    logic              re;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        wdata;
  } mem_req_t;

  // Finished result from the sequencer
  typedef struct packed {
    logic              valid;
    logic [PAGE_W-1:0] page;
    status_t           status;
  } res_t;

  // Index of the lowest clear bit of a byte (byte known not to be all ones)
  function automatic logic [2:0] first_zero(input logic [7:0] b);
    logic [2:0] pos;
    pos = 3'd0;
    for (int i = 7; i >= 0; i--) begin
      if (!b[i]) pos = 3'(i);
    end
    return pos;
  endfunction

  // Byte with the low n bits set
  function automatic logic [7:0] low_mask(input logic [2:0] n);
    logic [7:0] m;
    m = 8'h00;
    for (int i = 0; i < 8; i++) begin
      if (3'(i) < n) m[i] = 1'b1;
    end
    return m;
  endfunction

endpackage

/* src/pfba_in_if.sv */
// Command channel: valid/ready with command and page number.
interface pfba_in_if import pfba_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  command;
  logic [PAGE_W-1:0] page_number;

  modport source (output valid, output command, output page_number, input ready);
  modport sink   (input valid, input command, input page_number, output ready);
endinterface

/* src/pfba_out_if.sv */
// Result channel: valid/ready with result page and status.
interface pfba_out_if import pfba_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [PAGE_W-1:0] result_page;
  logic [STAT_W-1:0] status;

  modport source (output valid, output result_page, output status, input ready);
  modport sink   (input valid, input result_page, input status, output ready);
endinterface

/* src/pfba_cfg_if.sv */
// Register write channel: valid/ready with register index and data.
interface pfba_cfg_if import pfba_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CIDX_W-1:0] addr;
  logic [CFG_W-1:0]  data;

  modport source (output valid, output addr, output data, input ready);
  modport sink   (input valid, input addr, input data, output ready);
endinterface

/* src/pfba_map.sv */
// Used-bit map memory: one byte port, registered read data.
module pfba_map import pfba_pkg::*; (
  input  logic       clk,
  input  mem_req_t   req,
  output logic [7:0] rdata
);

  logic [7:0] mem [MAP_BYTES];

  // Write port
  always_ff @(posedge clk) begin
    if (req.we) mem[req.addr] <= req.wdata;
  end

  // Read port, data valid in the next cycle
  always_ff @(posedge clk) begin
    if (req.re) rdata <= mem[req.addr];
  end

endmodule

/* src/pfba_seq.sv */
// Command sequencer: byte scan, read-modify-write and map sweeps over the map port.
module pfba_seq import pfba_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [CMD_W-1:0]  in_command,
  input  logic [PAGE_W-1:0] in_page,
  input  logic [CFG_W-1:0]  usable,
  input  logic [CFG_W-1:0]  reserved,
  output logic              idle,
  output res_t              res,
  input  logic              res_taken,
  output mem_req_t          mem_req,
  input  logic [7:0]        rdata
);

  state_t              state_r, state_nxt;
  logic [ADDR_W-1:0]   addr_r, addr_nxt;
  logic [ADDR_W-1:0]   rd_addr_r, rd_addr_nxt;
  logic                chk_r, chk_nxt;
  cmd_t                cmd_r, cmd_nxt;
  logic [PAGE_W-1:0]   page_r, page_nxt;
  logic [PAGE_W-1:0]   res_page_r, res_page_nxt;
  status_t             res_status_r, res_status_nxt;
  logic [BCNT_W-1:0]   free_bytes_r, free_bytes_nxt;
  logic [BCNT_W-1:0]   resv_bytes_r, resv_bytes_nxt;
  logic [2:0]          resv_bits_r, resv_bits_nxt;

  cmd_t                cmd_in;
  logic [31:0]         lim32;
  logic [31:0]         resv32;
  logic [BCNT_W-1:0]   kx;
  logic [7:0]          init_byte;
  logic [7:0]          base_byte;
  logic [2:0]          fz;
  logic [7:0]          bit_mask;

  assign cmd_in   = cmd_t'(in_command);
  assign fz       = first_zero(rdata);
  assign bit_mask = 8'h01 << page_r[2:0];

  // Saturate the register values at the map size
  assign lim32  = (32'(usable) > 32'(NUM_PAGES)) ? 32'(NUM_PAGES) : 32'(usable);
  assign resv32 = (32'(reserved) > 32'(NUM_PAGES)) ? 32'(NUM_PAGES) : 32'(reserved);

  // Rebuilt value of the byte under the sweep address
  assign kx        = BCNT_W'(addr_r);
  assign base_byte = (kx < free_bytes_r) ? 8'h00 : BYTE_FULL;
  always_comb begin
    if (kx < resv_bytes_r) begin
      init_byte = BYTE_FULL;
    end else if (kx == resv_bytes_r) begin
      init_byte = base_byte | low_mask(resv_bits_r);
    end else begin
      init_byte = base_byte;
    end
  end

  // State and working registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      addr_r  <= '0;
      chk_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      addr_r  <= addr_nxt;
      chk_r   <= chk_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_addr_r    <= rd_addr_nxt;
    cmd_r        <= cmd_nxt;
    page_r       <= page_nxt;
    res_page_r   <= res_page_nxt;
    res_status_r <= res_status_nxt;
    free_bytes_r <= free_bytes_nxt;
    resv_bytes_r <= resv_bytes_nxt;
    resv_bits_r  <= resv_bits_nxt;
  end

  // Next state and map accesses
  always_comb begin
    state_nxt      = state_r;
    addr_nxt       = addr_r;
    rd_addr_nxt    = rd_addr_r;
    chk_nxt        = chk_r;
    cmd_nxt        = cmd_r;
    page_nxt       = page_r;
    res_page_nxt   = res_page_r;
    res_status_nxt = res_status_r;
    free_bytes_nxt = free_bytes_r;
    resv_bytes_nxt = resv_bytes_r;
    resv_bits_nxt  = resv_bits_r;
    mem_req        = '{we: 1'b0, re: 1'b0, addr: addr_r, wdata: 8'h00};

    case (state_r)
      // After reset every byte becomes all used
      ST_CLEAR: begin
        mem_req.we    = 1'b1;
        mem_req.wdata = BYTE_FULL;
        addr_nxt      = addr_r + 1'b1;
        if (addr_r == LAST_ADDR) state_nxt = ST_IDLE;
      end

      ST_IDLE: begin
        if (start) begin
          cmd_nxt        = cmd_in;
          page_nxt       = in_page;
          res_page_nxt   = in_page;
          res_status_nxt = STATUS_OK;
          case (cmd_in)
            CMD_ALLOC: begin
              addr_nxt  = '0;
              chk_nxt   = 1'b0;
              state_nxt = ST_SCAN;
            end
            CMD_FREE, CMD_MARK: begin
              if (32'(in_page) >= 32'(NUM_PAGES)) begin
                res_status_nxt = STATUS_RANGE;
                state_nxt      = ST_DONE;
              end else begin
                mem_req.re   = 1'b1;
                mem_req.addr = ADDR_W'(in_page >> 3);
                state_nxt    = ST_RMW;
              end
            end
            CMD_INIT: begin
              free_bytes_nxt = BCNT_W'(lim32 >> 3);
              resv_bytes_nxt = BCNT_W'(resv32 >> 3);
              resv_bits_nxt  = resv32[2:0];
              addr_nxt       = '0;
              state_nxt      = ST_INIT;
            end
            default: state_nxt = ST_IDLE;
          endcase
        end
      end

      // Stream reads byte by byte; check the byte read in the previous cycle
      ST_SCAN: begin
        if (chk_r && rdata != BYTE_FULL) begin
          mem_req.we    = 1'b1;
          mem_req.addr  = rd_addr_r;
          mem_req.wdata = rdata | (8'h01 << fz);
          res_page_nxt  = PAGE_W'({rd_addr_r, fz});
          state_nxt     = ST_DONE;
        end else if (chk_r && rd_addr_r == LAST_ADDR) begin
          res_page_nxt   = '0;
          res_status_nxt = STATUS_FULL;
          state_nxt      = ST_DONE;
        end else begin
          mem_req.re  = 1'b1;
          rd_addr_nxt = addr_r;
          chk_nxt     = 1'b1;
          addr_nxt    = addr_r + 1'b1;
        end
      end

      // Write back the byte with one bit changed
      ST_RMW: begin
        mem_req.we    = 1'b1;
        mem_req.addr  = ADDR_W'(page_r >> 3);
        mem_req.wdata = (cmd_r == CMD_FREE) ? (rdata & ~bit_mask) : (rdata | bit_mask);
        state_nxt     = ST_DONE;
      end

      // Rebuild the whole map from the registers
      ST_INIT: begin
        mem_req.we    = 1'b1;
        mem_req.wdata = init_byte;
        addr_nxt      = addr_r + 1'b1;
        if (addr_r == LAST_ADDR) state_nxt = ST_DONE;
      end

      ST_DONE: begin
        if (res_taken) state_nxt = ST_IDLE;
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  assign idle = (state_r == ST_IDLE);
  assign res  = '{valid: (state_r == ST_DONE), page: res_page_r, status: res_status_r};

endmodule

/* src/page_frame_bitmap_allocator_core.sv */
// Top level of the first-fit bitmap page frame allocator.
//
//  port    dir   word                          handshake
//  in_ch   sink  command, page_number          valid/ready
//  out_ch  src   result_page, status           valid/ready
//  cfg_ch  sink  addr (0 usable, 1 reserved),  valid/ready, always ready
//                data
//
// Alloc scans the map from byte 0, one map byte read per cycle through the single map
// port, and stops at the lowest byte with a free page, or after the last byte when the map is full.
// Free and mark_used read, modify and write back one byte; init rewrites every map byte,
// one byte written per cycle. After reset a clearing pass over every map byte sets every
// page used; in_ch is not ready meanwhile, register writes are taken.
// A result waits in the output register, so the next word may be accepted while it stalls.
module page_frame_bitmap_allocator_core import pfba_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  pfba_in_if.sink     in_ch,
  pfba_out_if.source  out_ch,
  pfba_cfg_if.sink    cfg_ch
);

  logic [CFG_W-1:0]  usable_r;
  logic [CFG_W-1:0]  reserved_r;
  logic              out_valid_r;
  logic [PAGE_W-1:0] out_page_r;
  status_t           out_status_r;

  logic              seq_idle;
  logic              res_taken;
  res_t              res;
  mem_req_t          mem_req;
  logic [7:0]        map_rdata;

  // Register writes
  assign cfg_ch.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      usable_r   <= USABLE_RST;
      reserved_r <= RESERVED_RST;
    end else if (cfg_ch.valid) begin
      case (cfg_reg_t'(cfg_ch.addr))
        CFG_USABLE:   usable_r   <= cfg_ch.data;
        CFG_RESERVED: reserved_r <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  assign in_ch.ready = seq_idle;

  pfba_seq u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (in_ch.valid && in_ch.ready),
    .in_command (in_ch.command),
    .in_page    (in_ch.page_number),
    .usable     (usable_r),
    .reserved   (reserved_r),
    .idle       (seq_idle),
    .res        (res),
    .res_taken  (res_taken),
    .mem_req    (mem_req),
    .rdata      (map_rdata)
  );

  pfba_map u_map (
    .clk   (clk),
    .req   (mem_req),
    .rdata (map_rdata)
  );

  // Output register
  assign res_taken = !out_valid_r || out_ch.ready;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_taken) begin
      out_valid_r <= res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_taken && res.valid) begin
      out_page_r   <= res.page;
      out_status_r <= res.status;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.result_page = out_page_r;
  assign out_ch.status      = out_status_r;

  // Clearing pass holds off commands right after reset
  a_clear_busy: assert property (@(posedge clk) !rst_n |=> !in_ch.ready)
    else $error("command accepted during clearing pass");

  // Every accepted command leaves the sequencer busy in the following cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> !in_ch.ready)
    else $error("ready right after a command was accepted");

  // Full map reports page zero
  a_full_page: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.status == STATUS_FULL |-> out_ch.result_page == '0)
    else $error("no-free-page result with nonzero page");

  // Single map port: never read and write in one cycle
  a_one_access: assert property (@(posedge clk) disable iff (!rst_n)
    !(mem_req.we && mem_req.re))
    else $error("map read and write in the same cycle");

endmodule

/* tb/page_frame_bitmap_allocator_core_tb.sv */
// Testbench for the page frame bitmap allocator: random commands checked against a bitmap model.
module page_frame_bitmap_allocator_core_tb;
  import pfba_pkg::*;

  localparam int STALL_LIMIT = 4000;  // cycles with no word moving before giving up
  localparam int HOLD_CYCLES = 300;   // long receiver hold-off
  localparam int DRAIN_CYCLES = 520;  // slowest alloc plus margin
  localparam int PHASES = 11;
  localparam int PHASE_WORDS = 102;

  typedef struct {
    logic [PAGE_W-1:0] page;
    status_t           status;
  } frame_result_t;

  // Bitmap model and queue of results still owed by the block
  class frame_map_scoreboard;
    bit                used[NUM_PAGES];
    logic [CFG_W-1:0]  usable_cnt;
    logic [CFG_W-1:0]  reserved_cnt;
    frame_result_t     owed_results[$];
    int                error_count;

    function new();
      foreach (used[p]) used[p] = 1'b1;
      usable_cnt   = USABLE_RST;
      reserved_cnt = RESERVED_RST;
      error_count  = 0;
    endfunction

    function void write_reg(cfg_reg_t idx, logic [CFG_W-1:0] val);
      if (idx == CFG_USABLE) usable_cnt = val;
      else reserved_cnt = val;
    endfunction

    // Apply one accepted command word to the map and queue its result
    function void note_command(cmd_t cmd, logic [PAGE_W-1:0] page);
      frame_result_t r;
      int found;
      int lim;
      int resv;
      r.page   = page;
      r.status = STATUS_OK;
      case (cmd)
        CMD_ALLOC: begin
          found = -1;
          for (int p = 0; p < NUM_PAGES; p++) begin
            if (!used[p]) begin
              found = p;
              break;
            end
          end
          if (found < 0) begin
            r.page   = '0;
            r.status = STATUS_FULL;
          end else begin
            used[found] = 1'b1;
            r.page      = PAGE_W'(found);
          end
        end
        CMD_FREE: begin
          if (int'(page) >= NUM_PAGES) r.status = STATUS_RANGE;
          else used[page] = 1'b0;
        end
        CMD_MARK: begin
          if (int'(page) >= NUM_PAGES) r.status = STATUS_RANGE;
          else used[page] = 1'b1;
        end
        default: begin
          // whole bytes below the usable count start free, kernel area used
          lim  = (int'(usable_cnt) > NUM_PAGES) ? NUM_PAGES : int'(usable_cnt);
          resv = (int'(reserved_cnt) > NUM_PAGES) ? NUM_PAGES : int'(reserved_cnt);
          for (int p = 0; p < NUM_PAGES; p++) used[p] = ((p / 8) < (lim / 8)) ? 1'b0 : 1'b1;
          for (int p = 0; p < resv; p++) used[p] = 1'b1;
        end
      endcase
      owed_results.push_back(r);
    endfunction

    function void check_result(logic [PAGE_W-1:0] page, logic [STAT_W-1:0] status);
      frame_result_t r;
      if (owed_results.size() == 0) begin
        $error("result word with no command pending: result_page %0d status %0d", page, status);
        error_count++;
        return;
      end
      r = owed_results.pop_front();
      if (page !== r.page) begin
        $error("result_page mismatch: expected %0d, actual %0d", r.page, page);
        error_count++;
      end
      if (status !== r.status) begin
        $error("status mismatch: expected %0d, actual %0d", r.status, status);
        error_count++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  bit   no_gaps;
  int   hold_requests = 0;  // long hold-offs asked of the result side
  int   idle_cycles = 0;
  frame_map_scoreboard sb;

  pfba_in_if  in_bus ();
  pfba_out_if out_bus ();
  pfba_cfg_if cfg_bus ();

  page_frame_bitmap_allocator_core i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_bus),
    .out_ch (out_bus),
    .cfg_ch (cfg_bus)
  );

  always #10 clk = ~clk;

  // Offer one command word after a random gap (none when no_gaps is set); return at the next falling edge
  task automatic send_word(input cmd_t cmd, input logic [PAGE_W-1:0] page);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_bus.valid       <= 1'b1;
    in_bus.command     <= cmd;
    in_bus.page_number <= page;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    sb.note_command(cmd, page);
    @(negedge clk);
  endtask

  // Stop offering and wait for every owed result
  task automatic wait_for_drain();
    in_bus.valid <= 1'b0;
    do @(negedge clk); while (sb.owed_results.size() != 0);
  endtask

  task automatic write_register(input cfg_reg_t idx, input logic [CFG_W-1:0] val);
    cfg_bus.valid <= 1'b1;
    cfg_bus.addr  <= idx;
    cfg_bus.data  <= val;
    @(posedge clk);
    while (!cfg_bus.ready) @(posedge clk);
    sb.write_reg(idx, val);
    @(negedge clk);
  endtask

  // Both registers, in random order; only called with the block idle
  task automatic load_registers(input logic [CFG_W-1:0] usable_val,
                                input logic [CFG_W-1:0] reserved_val);
    if ($urandom_range(0, 1)) begin
      write_register(CFG_USABLE, usable_val);
      write_register(CFG_RESERVED, reserved_val);
    end else begin
      write_register(CFG_RESERVED, reserved_val);
      write_register(CFG_USABLE, usable_val);
    end
    cfg_bus.valid <= 1'b0;
  endtask

  // One random phase: new register values, an init, then mixed commands
  task automatic run_phase(input int ph);
    int choice;
    int r;
    int low_top;
    logic [CFG_W-1:0] usable_val;
    logic [CFG_W-1:0] reserved_val;
    logic [PAGE_W-1:0] page;
    cmd_t cmd;
    choice = (ph < 2) ? ph + 6 : $urandom_range(0, 5);
    case (choice)
      0: begin
        usable_val   = CFG_W'(NUM_PAGES);
        reserved_val = CFG_W'($urandom_range(0, 64));
      end
      1: begin
        usable_val   = CFG_W'($urandom_range(0, 8191));
        reserved_val = CFG_W'($urandom_range(0, 8191));
      end
      2: begin
        // small map that fills up quickly
        usable_val   = CFG_W'($urandom_range(0, 600));
        reserved_val = CFG_W'($urandom_range(0, 40));
      end
      6: begin
        usable_val   = '1;
        reserved_val = '0;
      end
      7: begin
        usable_val   = '0;
        reserved_val = '1;
      end
      default: begin
        usable_val   = CFG_W'($urandom_range(64, NUM_PAGES));
        reserved_val = CFG_W'($urandom_range(0, 300));
      end
    endcase
    no_gaps = ($urandom_range(0, 3) == 0);
    load_registers(usable_val, reserved_val);
    low_top = (int'(reserved_val) > NUM_PAGES - 64) ? NUM_PAGES - 1 : int'(reserved_val) + 63;
    send_word(CMD_INIT, PAGE_W'($urandom_range(0, NUM_PAGES - 1)));
    for (int i = 1; i < PHASE_WORDS; i++) begin
      // receiver stalls for a long stretch while commands keep coming
      if ((ph == 3 || ph == 8) && i == 20) hold_requests++;
      r = $urandom_range(0, 99);
      if (r < 45) cmd = CMD_ALLOC;
      else if (r < 75) cmd = CMD_FREE;
      else if (r < 90) cmd = CMD_MARK;
      else cmd = CMD_INIT;
      r = $urandom_range(0, 99);
      if (r < 40) page = PAGE_W'($urandom_range(0, low_top));
      else if (r < 55) page = PAGE_W'($urandom_range(NUM_PAGES - 64, NUM_PAGES - 1));
      else page = PAGE_W'($urandom_range(0, NUM_PAGES - 1));
      send_word(cmd, page);
    end
    wait_for_drain();
  endtask

  // Result side: random ready gaps, long hold-off on request
  initial begin
    int gap;
    int holds_served;
    holds_served  = 0;
    out_bus.ready = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      if (hold_requests != holds_served) begin
        holds_served++;
        gap = HOLD_CYCLES;
      end else begin
        gap = no_gaps ? 0 : $urandom_range(0, 11);
      end
      if (gap > 0) begin
        out_bus.ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_bus.ready <= 1'b1;
      @(posedge clk);
      while (!out_bus.valid) @(posedge clk);
      sb.check_result(out_bus.result_page, out_bus.status);
      @(negedge clk);
    end
  end

  // Watchdog on cycles where no word moves on any channel
  always @(posedge clk) begin
    if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready) ||
        (cfg_bus.valid && cfg_bus.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    sb                 = new();
    no_gaps            = 1'b0;
    rst_n              = 1'b0;
    in_bus.valid       = 1'b0;
    in_bus.command     = CMD_ALLOC;
    in_bus.page_number = '0;
    cfg_bus.valid      = 1'b0;
    cfg_bus.addr       = CFG_USABLE;
    cfg_bus.data       = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Map still all used after reset: alloc finds nothing
    send_word(CMD_ALLOC, 12'h000);
    send_word(CMD_FREE, 12'hFFF);
    send_word(CMD_ALLOC, 12'h000);
    send_word(CMD_MARK, 12'h000);
    // init with reset registers; output echoes the page
    send_word(CMD_INIT, 12'hABC);
    send_word(CMD_ALLOC, 12'h000);
    send_word(CMD_FREE, 12'h005);
    send_word(CMD_ALLOC, 12'h000);
    send_word(CMD_MARK, 12'h801);
    send_word(CMD_ALLOC, 12'h7FF);
    wait_for_drain();

    // Partial last byte: only the first whole byte comes free, then full
    load_registers(13'd13, 13'd0);
    send_word(CMD_INIT, 12'h000);
    repeat (9) send_word(CMD_ALLOC, 12'h000);
    wait_for_drain();

    // Oversized registers saturate: everything reserved
    load_registers(13'h1FFF, 13'd4097);
    send_word(CMD_INIT, 12'h555);
    send_word(CMD_ALLOC, 12'h000);
    send_word(CMD_MARK, 12'hFFF);
    send_word(CMD_FREE, 12'h555);
    send_word(CMD_ALLOC, 12'h000);
    wait_for_drain();

    for (int ph = 0; ph < PHASES; ph++) run_phase(ph);

    // Let any stray result show up before the verdict
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.error_count == 0 && sb.owed_results.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

/* files.f */
src/pfba_pkg.sv
src/pfba_in_if.sv
src/pfba_out_if.sv
src/pfba_cfg_if.sv
src/pfba_map.sv
src/pfba_seq.sv
src/page_frame_bitmap_allocator_core.sv
tb/page_frame_bitmap_allocator_core_tb.sv
